### hdl/rgb_hsv_color_classifier_assert.svh
// assertion macros for the rgb hsv color classifier
// no dependencies
`ifndef RGB_HSV_COLOR_CLASSIFIER_ASSERT_SVH
`define RGB_HSV_COLOR_CLASSIFIER_ASSERT_SVH

// clocked implication check, disabled while reset is high
`define RHC_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("rhc check failed");

// clocked next-cycle check
`define RHC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("rhc check failed");

`endif

### hdl/rhc_pkg.sv
// shared types and constants for the rgb hsv color classifier
// no dependencies
package rhc_pkg;

   localparam int unsigned ChanW   = 16;
   localparam int unsigned DistW   = 9;
   localparam int unsigned HueW    = 15;
   localparam int unsigned SatW    = 11;
   localparam int unsigned HqW     = 12;
   localparam int unsigned HremW   = 28;
   localparam int unsigned SremW   = 27;
   localparam int unsigned DivSteps = 12;

   localparam logic [11:0] HuePerSector = 12'd3840;
   localparam logic [HueW-1:0] HueFullTurn = 15'd23040;
   localparam logic [HueW-1:0] GreenBase   = 15'd7680;
   localparam logic [HueW-1:0] BlueBase    = 15'd15360;
   localparam logic [HueW-1:0] RedAbove    = 15'd21120;
   localparam logic [HueW-1:0] RedBelow    = 15'd1920;

   typedef enum logic [2:0] {
      CSR_SAT_MIN   = 3'd0,
      CSR_NEAR_DIST = 3'd1,
      CSR_DARK_AMB  = 3'd2,
      CSR_GREEN_LO  = 3'd3,
      CSR_GREEN_HI  = 3'd4,
      CSR_BLUE_LO   = 3'd5,
      CSR_BLUE_HI   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      CLASS_NONE  = 2'd0,
      CLASS_RED   = 2'd1,
      CLASS_GREEN = 2'd2,
      CLASS_BLUE  = 2'd3
   } color_class_type;

   typedef enum logic [1:0] {
      SEC_RED   = 2'd0,
      SEC_GREEN = 2'd1,
      SEC_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      sector_type        sector;
      logic              neg;
      logic              gray;
      logic [ChanW-1:0]  dabs;
      logic [ChanW-1:0]  mx;
      logic [ChanW-1:0]  delta;
      logic [ChanW-1:0]  amb;
      logic [DistW-1:0]  distance;
   } front_type;

   typedef struct packed {
      sector_type        sector;
      logic              neg;
      logic              gray;
      logic [ChanW-1:0]  mx;
      logic [ChanW-1:0]  delta;
      logic [HremW-1:0]  hrem;
      logic [SremW-1:0]  srem;
      logic [HqW-1:0]    hq;
      logic [SatW-1:0]   sq;
      logic [ChanW-1:0]  amb;
      logic [DistW-1:0]  distance;
   } div_type;

endpackage

### hdl/rgb_hsv_color_classifier.sv
// rgb hsv color classifier top level: pipelined max/min, two dividers, classify
// depends on rhc_pkg
//
// channel | ports                            | handshake
// req     | red green blue ambient distance  | req_valid / req_stall
// rsp     | hue saturation brightness cls    | rsp_valid / rsp_stall
// csr     | csr_index csr_data               | csr_write
//
// one beat per cycle while no valid rsp is stalled; req passes front, divider and rsp registers
// the 12 bit restoring divider chain yields one quotient bit per stage
// reset clears valid bits and loads register defaults
// a stalled valid rsp freezes the whole pipeline, req_stall follows
module rgb_hsv_color_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_red,
   input  logic [15:0] req_green,
   input  logic [15:0] req_blue,
   input  logic [15:0] req_ambient,
   input  logic [8:0]  req_distance,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_hue,
   output logic [10:0] rsp_saturation,
   output logic [15:0] rsp_brightness,
   output logic [1:0]  rsp_color_class,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [10:0] sat_min_ff;
   logic [8:0]  near_dist_ff;
   logic [15:0] dark_amb_ff;
   logic [14:0] green_lo_ff, green_hi_ff, blue_lo_ff, blue_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_min_ff   <= 11'd512;
         near_dist_ff <= 9'd192;
         dark_amb_ff  <= 16'd200;
         green_lo_ff  <= 15'd5440;
         green_hi_ff  <= 15'd10560;
         blue_lo_ff   <= 15'd11200;
         blue_hi_ff   <= 15'd17280;
      end else if (csr_write) begin
         unique case (csr_index)
            rhc_pkg::CSR_SAT_MIN:   sat_min_ff   <= csr_data[10:0];
            rhc_pkg::CSR_NEAR_DIST: near_dist_ff <= csr_data[8:0];
            rhc_pkg::CSR_DARK_AMB:  dark_amb_ff  <= csr_data;
            rhc_pkg::CSR_GREEN_LO:  green_lo_ff  <= csr_data[14:0];
            rhc_pkg::CSR_GREEN_HI:  green_hi_ff  <= csr_data[14:0];
            rhc_pkg::CSR_BLUE_LO:   blue_lo_ff   <= csr_data[14:0];
            rhc_pkg::CSR_BLUE_HI:   blue_hi_ff   <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // front stage: max, min, sector, signed offset
   rhc_pkg::front_type front_in, front_ff;
   logic front_valid_ff;
   logic [15:0] mx, mn;
   logic [16:0] diff;

   always_comb begin
      mx = (req_red > req_green) ? req_red : req_green;
      mx = (mx > req_blue) ? mx : req_blue;
      mn = (req_red < req_green) ? req_red : req_green;
      mn = (mn < req_blue) ? mn : req_blue;
      if (req_red >= mx) begin
         front_in.sector = rhc_pkg::SEC_RED;
         diff = {1'b0, req_green} - {1'b0, req_blue};
      end else if (req_green >= mx) begin
         front_in.sector = rhc_pkg::SEC_GREEN;
         diff = {1'b0, req_blue} - {1'b0, req_red};
      end else begin
         front_in.sector = rhc_pkg::SEC_BLUE;
         diff = {1'b0, req_red} - {1'b0, req_green};
      end
      front_in.neg      = diff[16];
      front_in.dabs     = diff[16] ? 16'(-diff) : diff[15:0];
      front_in.mx       = mx;
      front_in.delta    = mx - mn;
      front_in.gray     = (mx == mn);
      front_in.amb      = req_ambient;
      front_in.distance = req_distance;
   end

   always_ff @(posedge clock) begin
      if (reset) front_valid_ff <= 1'b0;
      else if (en) front_valid_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (en) front_ff <= front_in;
   end

   // multiply stage and divider chain
   rhc_pkg::div_type div_ff [0:rhc_pkg::DivSteps];
   logic             div_valid_ff [0:rhc_pkg::DivSteps];
   rhc_pkg::div_type div0_in;

   always_comb begin
      div0_in.sector   = front_ff.sector;
      div0_in.neg      = front_ff.neg;
      div0_in.gray     = front_ff.gray;
      div0_in.mx       = front_ff.mx;
      div0_in.delta    = front_ff.delta;
      div0_in.hrem     = 28'(front_ff.dabs) * 28'(rhc_pkg::HuePerSector);
      div0_in.srem     = {1'b0, front_ff.delta, 10'd0};
      div0_in.hq       = '0;
      div0_in.sq       = '0;
      div0_in.amb      = front_ff.amb;
      div0_in.distance = front_ff.distance;
   end

   always_ff @(posedge clock) begin
      if (reset) div_valid_ff[0] <= 1'b0;
      else if (en) div_valid_ff[0] <= front_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (en) div_ff[0] <= div0_in;
   end

   for (genvar i = 0; i < rhc_pkg::DivSteps; i++) begin : g_div
      localparam int Sh = rhc_pkg::DivSteps - 1 - i;
      rhc_pkg::div_type step_in;
      logic [27:0] hdiv;
      always_comb begin
         step_in = div_ff[i];
         hdiv = 28'(div_ff[i].delta) << Sh;
         if (div_ff[i].hrem >= hdiv) begin
            step_in.hrem   = div_ff[i].hrem - hdiv;
            step_in.hq[Sh] = 1'b1;
         end
      end
      if (Sh <= 10) begin : g_sat
         logic [26:0] sdiv;
         rhc_pkg::div_type sat_in;
         always_comb begin
            sat_in = step_in;
            sdiv = 27'(div_ff[i].mx) << Sh;
            if (div_ff[i].srem >= sdiv) begin
               sat_in.srem   = div_ff[i].srem - sdiv;
               sat_in.sq[Sh] = 1'b1;
            end
         end
         always_ff @(posedge clock) begin
            if (en) div_ff[i+1] <= sat_in;
         end
      end else begin : g_nosat
         always_ff @(posedge clock) begin
            if (en) div_ff[i+1] <= step_in;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) div_valid_ff[i+1] <= 1'b0;
         else if (en) div_valid_ff[i+1] <= div_valid_ff[i];
      end
   end

   // hue assembly and classify
   rhc_pkg::div_type last;
   logic [14:0] hue_in, base, q15;
   logic [10:0] sat_in;
   rhc_pkg::color_class_type cls_in;
   logic remnz;

   always_comb begin
      last  = div_ff[rhc_pkg::DivSteps];
      q15   = 15'(last.hq);
      remnz = (last.hrem != '0);
      case (last.sector)
         rhc_pkg::SEC_GREEN: base = rhc_pkg::GreenBase;
         rhc_pkg::SEC_BLUE:  base = rhc_pkg::BlueBase;
         default:            base = '0;
      endcase
      if (last.gray) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         sat_in = last.sq;
         if (last.sector == rhc_pkg::SEC_RED) begin
            if (last.neg && q15 != '0) hue_in = rhc_pkg::HueFullTurn - q15;
            else if (last.neg)         hue_in = '0;
            else                       hue_in = q15;
         end else if (last.neg) begin
            hue_in = base - q15 - 15'(remnz);
         end else begin
            hue_in = base + q15;
         end
      end
      if (sat_in < sat_min_ff)
         cls_in = rhc_pkg::CLASS_NONE;
      else if (last.distance < near_dist_ff && last.amb < dark_amb_ff)
         cls_in = rhc_pkg::CLASS_NONE;
      else if (hue_in > green_lo_ff && hue_in < green_hi_ff)
         cls_in = rhc_pkg::CLASS_GREEN;
      else if (hue_in > blue_lo_ff && hue_in < blue_hi_ff)
         cls_in = rhc_pkg::CLASS_BLUE;
      else if (hue_in > rhc_pkg::RedAbove || hue_in < rhc_pkg::RedBelow)
         cls_in = rhc_pkg::CLASS_RED;
      else
         cls_in = rhc_pkg::CLASS_NONE;
   end

   logic rsp_valid_ff;
   logic [14:0] hue_ff;
   logic [10:0] sat_ff;
   logic [15:0] bright_ff;
   rhc_pkg::color_class_type cls_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= div_valid_ff[rhc_pkg::DivSteps];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= last.mx;
         cls_ff    <= cls_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hue         = hue_ff;
   assign rsp_saturation  = sat_ff;
   assign rsp_brightness  = bright_ff;
   assign rsp_color_class = cls_ff;

endmodule

### hdl/rhc_checker.sv
// port level checks for the rgb hsv color classifier, bound to the top level
// depends on rgb_hsv_color_classifier_assert.svh
`include "rgb_hsv_color_classifier_assert.svh"
module rhc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [14:0] rsp_hue,
   input logic [10:0] rsp_saturation
);
   `RHC_ASSERT_IMPL(a_hue_range, clock, reset, rsp_valid, rsp_hue < 15'd23040)
   `RHC_ASSERT_IMPL(a_sat_range, clock, reset, rsp_valid, rsp_saturation <= 11'd1024)
   `RHC_ASSERT_IMPL(a_stall_back, clock, reset, rsp_valid && rsp_stall, req_stall)
   `RHC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
endmodule

bind rgb_hsv_color_classifier rhc_checker u_rhc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hue        (rsp_hue),
   .rsp_saturation (rsp_saturation)
);

### tb/tb_rgb_hsv_color_classifier.sv
// self-checking testbench for rgb_hsv_color_classifier: directed and random readings,
// integer hsv prediction, random idle/stall phases and register changes
// depends on rhc_pkg and the rgb_hsv_color_classifier rtl
module tb_rgb_hsv_color_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] red, green, blue, ambient;
      logic [8:0]  distance;
   } reading_type;

   typedef struct {
      logic [14:0] hue;
      logic [10:0] sat;
      logic [15:0] bright;
      rhc_pkg::color_class_type cls;
   } hsv_type;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_write;
   logic [15:0] req_red, req_green, req_blue, req_ambient, csr_data;
   logic [8:0]  req_distance;
   logic [14:0] rsp_hue;
   logic [10:0] rsp_saturation;
   logic [15:0] rsp_brightness;
   logic [1:0]  rsp_color_class;
   rhc_pkg::csr_index_type csr_index;

   reading_type pending_readings[$];
   hsv_type     expected_hsv[$];
   logic [15:0] reg_shadow[7];
   int send_idle_pct, recv_stall_pct, mismatches;
   bit failed;

   rgb_hsv_color_classifier u_dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic hsv_type classify(reading_type rd);
      hsv_type o;
      longint r, g, b, mx, mn, d, num, h;
      logic [10:0] smin;
      r = rd.red; g = rd.green; b = rd.blue;
      mx = r > g ? r : g; mx = mx > b ? mx : b;
      mn = r < g ? r : g; mn = mn < b ? mn : b;
      d = mx - mn;
      o.hue = 0; o.sat = 0; o.bright = mx[15:0];
      if (d > 0) begin
         o.sat = 11'((d * 1024) / mx);
         if (r >= mx) num = g - b;
         else if (g >= mx) num = 2 * d + (b - r);
         else num = 4 * d + (r - g);
         h = (num * 3840) / d;
         if (h < 0) h += 23040;
         o.hue = 15'(h);
      end
      smin = reg_shadow[rhc_pkg::CSR_SAT_MIN][10:0];
      if (o.sat < smin) o.cls = rhc_pkg::CLASS_NONE;
      else if (rd.distance < reg_shadow[rhc_pkg::CSR_NEAR_DIST][8:0]
               && rd.ambient < reg_shadow[rhc_pkg::CSR_DARK_AMB])
         o.cls = rhc_pkg::CLASS_NONE;
      else if (o.hue > reg_shadow[rhc_pkg::CSR_GREEN_LO][14:0]
               && o.hue < reg_shadow[rhc_pkg::CSR_GREEN_HI][14:0])
         o.cls = rhc_pkg::CLASS_GREEN;
      else if (o.hue > reg_shadow[rhc_pkg::CSR_BLUE_LO][14:0]
               && o.hue < reg_shadow[rhc_pkg::CSR_BLUE_HI][14:0])
         o.cls = rhc_pkg::CLASS_BLUE;
      else if (o.hue > 21120 || o.hue < 1920) o.cls = rhc_pkg::CLASS_RED;
      else o.cls = rhc_pkg::CLASS_NONE;
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_hsv.push_back(classify('{req_red, req_green, req_blue,
                                                          req_ambient, req_distance}));
         if (pending_readings.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            reading_type rd;
            rd = pending_readings.pop_front();
            req_valid <= 1;
            req_red <= rd.red; req_green <= rd.green; req_blue <= rd.blue;
            req_ambient <= rd.ambient; req_distance <= rd.distance;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_hsv.size() == 0) begin
               failed = 1;
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat hue %0d", rsp_hue);
            end else begin
               hsv_type e;
               e = expected_hsv.pop_front();
               if (rsp_hue !== e.hue || rsp_saturation !== e.sat
                   || rsp_brightness !== e.bright || rsp_color_class !== e.cls) begin
                  failed = 1;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp h%0d s%0d v%0d c%0d got h%0d s%0d v%0d c%0d",
                              e.hue, e.sat, e.bright, e.cls, rsp_hue, rsp_saturation,
                              rsp_brightness, rsp_color_class);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic add_reading(int r, int g, int b, int a, int d);
      pending_readings.push_back('{r[15:0], g[15:0], b[15:0], a[15:0], d[8:0]});
   endtask

   task automatic drain();
      while (pending_readings.size() > 0 || req_valid || expected_hsv.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(rhc_pkg::csr_index_type idx, int val);
      @(posedge clock);
      csr_write <= 1; csr_index <= idx; csr_data <= val[15:0];
      reg_shadow[idx] = val[15:0];
      @(posedge clock);
      csr_write <= 0;
   endtask

   task automatic random_readings(int n);
      int v, k;
      repeat (n) begin
         v = $urandom_range(3);
         k = $urandom_range(9);
         if (k < 2) add_reading($urandom, $urandom, $urandom, $urandom, $urandom);
         else if (k < 4) begin
            int c;
            c = $urandom;
            add_reading(c, c + $urandom_range(2) - 1, c, $urandom_range(400),
                        $urandom_range(511));
         end else if (k < 7)
            add_reading($urandom_range(255), $urandom_range(255), $urandom_range(255),
                        $urandom_range(500), $urandom_range(511));
         else
            add_reading(v == 0 ? 65535 : $urandom_range(65535), $urandom_range(65535),
                        v == 1 ? 0 : $urandom_range(65535), $urandom, $urandom);
      end
   endtask

   task automatic random_regs();
      write_reg(rhc_pkg::CSR_SAT_MIN, $urandom_range(1100));
      write_reg(rhc_pkg::CSR_NEAR_DIST, $urandom_range(511));
      write_reg(rhc_pkg::CSR_DARK_AMB, $urandom_range(65535));
      write_reg(rhc_pkg::CSR_GREEN_LO, $urandom_range(23039));
      write_reg(rhc_pkg::CSR_GREEN_HI, $urandom_range(23039));
      write_reg(rhc_pkg::CSR_BLUE_LO, $urandom_range(23039));
      write_reg(rhc_pkg::CSR_BLUE_HI, $urandom_range(23039));
   endtask

   initial begin
      reset = 1; req_valid = 0; rsp_stall = 0; csr_write = 0;
      csr_index = rhc_pkg::CSR_SAT_MIN; csr_data = 0;
      req_red = 0; req_green = 0; req_blue = 0; req_ambient = 0; req_distance = 0;
      send_idle_pct = 0; recv_stall_pct = 0; mismatches = 0; failed = 0;
      reg_shadow = '{512, 192, 200, 5440, 10560, 11200, 17280};
      repeat (5) @(posedge clock);
      reset <= 0;
      // directed: gray, extremes, ties, every band, dark and near
      add_reading(0, 0, 0, 0, 0);
      add_reading(65535, 65535, 65535, 65535, 511);
      add_reading(65535, 0, 0, 1000, 511);
      add_reading(0, 65535, 0, 1000, 511);
      add_reading(0, 0, 65535, 1000, 511);
      add_reading(65535, 0, 65535, 1000, 511);
      add_reading(65535, 65535, 0, 1000, 511);
      add_reading(0, 65535, 65535, 1000, 511);
      add_reading(100, 0, 1, 1000, 511);
      add_reading(100, 100, 0, 1000, 511);
      add_reading(0, 100, 100, 1000, 511);
      add_reading(200, 100, 100, 0, 0);
      add_reading(200, 100, 100, 65535, 0);
      add_reading(1, 0, 0, 199, 191);
      add_reading(43690, 21845, 65535, 65535, 256);
      add_reading(1023, 511, 512, 12345, 300);
      drain();
      write_reg(rhc_pkg::CSR_SAT_MIN, 0);
      write_reg(rhc_pkg::CSR_NEAR_DIST, 0);
      write_reg(rhc_pkg::CSR_DARK_AMB, 0);
      add_reading(50, 50, 50, 0, 0);
      add_reading(0, 0, 0, 0, 0);
      add_reading(10, 20, 30, 0, 0);
      drain();
      write_reg(rhc_pkg::CSR_SAT_MIN, 1024);
      write_reg(rhc_pkg::CSR_NEAR_DIST, 511);
      write_reg(rhc_pkg::CSR_DARK_AMB, 65535);
      write_reg(rhc_pkg::CSR_GREEN_LO, 0);
      write_reg(rhc_pkg::CSR_GREEN_HI, 23039);
      write_reg(rhc_pkg::CSR_BLUE_LO, 32767);
      write_reg(rhc_pkg::CSR_BLUE_HI, 32767);
      add_reading(65535, 0, 0, 65535, 511);
      add_reading(0, 100, 0, 0, 0);
      drain();
      write_reg(rhc_pkg::CSR_SAT_MIN, 2047);
      add_reading(0, 100, 0, 500, 511);
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         if (ph == 0) begin
            write_reg(rhc_pkg::CSR_SAT_MIN, 512); write_reg(rhc_pkg::CSR_NEAR_DIST, 192);
            write_reg(rhc_pkg::CSR_DARK_AMB, 200); write_reg(rhc_pkg::CSR_GREEN_LO, 5440);
            write_reg(rhc_pkg::CSR_GREEN_HI, 10560); write_reg(rhc_pkg::CSR_BLUE_LO, 11200);
            write_reg(rhc_pkg::CSR_BLUE_HI, 17280);
         end else if (ph % 2 == 1) begin
            write_reg(rhc_pkg::CSR_SAT_MIN, $urandom_range(700));
            write_reg(rhc_pkg::CSR_NEAR_DIST, $urandom_range(511));
            write_reg(rhc_pkg::CSR_DARK_AMB, $urandom_range(400));
         end else begin
            random_regs();
         end
         random_readings(120);
         drain();
      end
      send_idle_pct = 0; recv_stall_pct = 0;
      if (!failed) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule

### sim.f
+incdir+hdl
hdl/rhc_pkg.sv
hdl/rgb_hsv_color_classifier.sv
hdl/rhc_checker.sv
tb/tb_rgb_hsv_color_classifier.sv
